@@ rtl/fco_pkg.sv @@
// fco_pkg: shared types, constants and helper functions for the fly camera block
// no dependencies; used by fco_cordic, fco_mul and fly_camera_orientation_update
`timescale 1ns / 1ps
`default_nettype none
package fco_pkg;

  // angles in degrees Q16.16
  localparam logic signed [31:0] DEG89  = 32'sd5832704;
  localparam logic signed [31:0] DEG90  = 32'sd5898240;
  localparam logic signed [31:0] DEG180 = 32'sd11796480;
  localparam logic signed [32:0] DEG360 = 33'sd23592960;
  localparam logic signed [15:0] TENTH_Q16 = 16'sd6554;

  // cordic datapath, Q2.30 with a guard bit
  localparam int unsigned CW = 34;
  localparam logic signed [CW-1:0] CORDIC_K = 34'sd652032874;

  // bit-serial multiplier
  localparam int unsigned MUL_W = 34;
  localparam int unsigned PROD_W = 2 * MUL_W;
  localparam int unsigned MUL_CNT_W = 6;

  // unit vector and zoom limits
  localparam logic signed [15:0] ONE_V = 16'sd16384;
  localparam logic signed [18:0] ZOOM_MIN = 19'sd256;
  localparam logic signed [18:0] ZOOM_MAX = 19'sd11520;

  // commands
  localparam logic [1:0] CMD_LOOK  = 2'd0;
  localparam logic [1:0] CMD_MOVE  = 2'd1;
  localparam logic [1:0] CMD_ZOOM  = 2'd2;
  localparam logic [1:0] CMD_START = 2'd3;

  // move directions
  localparam logic [2:0] DIR_FWD   = 3'd0;
  localparam logic [2:0] DIR_BACK  = 3'd1;
  localparam logic [2:0] DIR_RIGHT = 3'd2;
  localparam logic [2:0] DIR_LEFT  = 3'd3;
  localparam logic [2:0] DIR_UP    = 3'd4;
  localparam logic [2:0] DIR_DOWN  = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE, S_CY_GO, S_CY_RUN, S_CP_GO, S_CP_RUN, S_LM_GO, S_LM_RUN,
    S_VEL_GO, S_VEL_RUN, S_MV_GO, S_MV_RUN, S_OUT
  } seq_state_e;

  // arctangent table in degrees Q16.16
  function automatic logic signed [31:0] atan_deg(input logic [4:0] idx);
    logic signed [31:0] r;
    case (idx)
      5'd0:  r = 32'sd2949120;
      5'd1:  r = 32'sd1740967;
      5'd2:  r = 32'sd919879;
      5'd3:  r = 32'sd466945;
      5'd4:  r = 32'sd234379;
      5'd5:  r = 32'sd117304;
      5'd6:  r = 32'sd58666;
      5'd7:  r = 32'sd29335;
      5'd8:  r = 32'sd14667;
      5'd9:  r = 32'sd7334;
      5'd10: r = 32'sd3667;
      5'd11: r = 32'sd1833;
      5'd12: r = 32'sd917;
      5'd13: r = 32'sd458;
      5'd14: r = 32'sd229;
      5'd15: r = 32'sd115;
      5'd16: r = 32'sd57;
      5'd17: r = 32'sd29;
      5'd18: r = 32'sd14;
      5'd19: r = 32'sd7;
      5'd20: r = 32'sd4;
      5'd21: r = 32'sd2;
      5'd22: r = 32'sd1;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  // round half up by 16 bits and clamp to a unit vector component
  function automatic logic signed [15:0] q14_s16(input logic signed [CW-1:0] v);
    logic signed [CW:0] t;
    logic signed [CW:0] s;
    logic signed [15:0] r;
    t = (CW+1)'(v) + (CW+1)'(32768);
    s = t >>> 16;
    if (s > (CW+1)'(ONE_V)) r = ONE_V;
    else if (s < -(CW+1)'(ONE_V)) r = -ONE_V;
    else r = s[15:0];
    return r;
  endfunction

  // round half up by 46 bits and clamp to a unit vector component
  function automatic logic signed [15:0] q14_s46(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W:0] t;
    logic signed [PROD_W:0] s;
    logic signed [15:0] r;
    t = (PROD_W+1)'(v) + ((PROD_W+1)'(1) <<< 45);
    s = t >>> 46;
    if (s > (PROD_W+1)'(ONE_V)) r = ONE_V;
    else if (s < -(PROD_W+1)'(ONE_V)) r = -ONE_V;
    else r = s[15:0];
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/fco_mul.sv @@
// fco_mul: bit-serial signed shift-add multiplier, one multiplier bit per cycle
// depends on fco_pkg
`timescale 1ns / 1ps
`default_nettype none
module fco_mul (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  input  wire logic signed [fco_pkg::MUL_W-1:0]     a_i,
  input  wire logic signed [fco_pkg::MUL_W-1:0]     b_i,
  output logic                                      done_o,
  output logic signed [fco_pkg::PROD_W-1:0]         prod_o
);

  logic                                  busy_q;
  logic                                  done_q;
  logic [fco_pkg::MUL_CNT_W-1:0]         cnt_q;
  logic signed [fco_pkg::PROD_W-1:0]     mcand_q;
  logic [fco_pkg::MUL_W-1:0]             mplier_q;
  logic signed [fco_pkg::PROD_W-1:0]     acc_q;
  logic signed [fco_pkg::PROD_W-1:0]     acc_d;
  logic                                  last;

  // the sign bit of the multiplier carries negative weight
  always_comb begin
    last = (cnt_q == fco_pkg::MUL_CNT_W'(fco_pkg::MUL_W - 1));
    acc_d = acc_q;
    if (mplier_q[0]) begin
      if (last) acc_d = acc_q - mcand_q;
      else acc_d = acc_q + mcand_q;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operand shift registers and accumulator
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q  <= fco_pkg::PROD_W'(a_i);
      mplier_q <= b_i;
      acc_q    <= '0;
    end else if (busy_q) begin
      mcand_q  <= mcand_q <<< 1;
      mplier_q <= mplier_q >> 1;
      acc_q    <= acc_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule
`default_nettype wire

@@ rtl/fco_cordic.sv @@
// fco_cordic: iterative rotation cordic, sine and cosine of an angle in degrees
// depends on fco_pkg; one micro-rotation per cycle
`timescale 1ns / 1ps
`default_nettype none
module fco_cordic #(
  parameter int unsigned STEPS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic signed [31:0]                angle_i,
  output logic                                   done_o,
  output logic signed [fco_pkg::CW-1:0]          cos_o,
  output logic signed [fco_pkg::CW-1:0]          sin_o
);

  localparam int unsigned IW = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic                             busy_q;
  logic                             done_q;
  logic                             neg_q;
  logic [IW-1:0]                    cnt_q;
  logic signed [fco_pkg::CW-1:0]    x_q, y_q, cos_q, sin_q;
  logic signed [31:0]               z_q;
  logic signed [fco_pkg::CW-1:0]    xs, ys, x_d, y_d;
  logic signed [31:0]               z_d, a_fold, at;
  logic                             neg_fold, last;

  // fold the angle into plus or minus ninety degrees
  always_comb begin
    a_fold = angle_i;
    neg_fold = 1'b0;
    if (angle_i > fco_pkg::DEG90) begin
      a_fold = angle_i - fco_pkg::DEG180;
      neg_fold = 1'b1;
    end else if (angle_i < -fco_pkg::DEG90) begin
      a_fold = angle_i + fco_pkg::DEG180;
      neg_fold = 1'b1;
    end
  end

  // one micro-rotation
  always_comb begin
    at = fco_pkg::atan_deg(5'(cnt_q));
    xs = x_q >>> cnt_q;
    ys = y_q >>> cnt_q;
    last = (cnt_q == IW'(STEPS - 1));
    if (z_q >= 0) begin
      x_d = x_q - ys;
      y_d = y_q + xs;
      z_d = z_q - at;
    end else begin
      x_d = x_q + ys;
      y_d = y_q - xs;
      z_d = z_q + at;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= fco_pkg::CORDIC_K;
      y_q   <= '0;
      z_q   <= a_fold;
      neg_q <= neg_fold;
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
      if (last) begin
        cos_q <= neg_q ? -x_d : x_d;
        sin_q <= neg_q ? -y_d : y_d;
      end
    end
  end

  assign done_o = done_q;
  assign cos_o  = cos_q;
  assign sin_o  = sin_q;

endmodule
`default_nettype wire

@@ rtl/fly_camera_orientation_update.sv @@
// fly camera: yaw/pitch orientation, position, basis vectors and zoom
// from accept to result valid: look runs two cordic runs (yaw, then pitch), four
// bit-serial products and the output state; move runs the speed product, then one
// product per axis (an invalid direction goes straight to output); zoom and start go
// straight to output. One transaction at a time: the next is accepted in the cycle after
// the result is registered; a stalled result holds the sequencer in its output state
// reset (rst_ni low, asynchronous): yaw -90, pitch 0, position 0, front (0,0,-1),
// right (1,0,0), up (0,1,0), zoom 45, move_speed 2.5; output empty.
// depends on fco_pkg, fco_cordic, fco_mul
`timescale 1ns / 1ps
`default_nettype none
module fly_camera_orientation_update #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [15:0]        move_speed_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         command_i,
  input  wire logic signed [10:0] dx_i,
  input  wire logic signed [10:0] dy_i,
  input  wire logic [2:0]         move_dir_i,
  input  wire logic [15:0]        dt_i,
  input  wire logic signed [31:0] set_x_i,
  input  wire logic signed [31:0] set_y_i,
  input  wire logic signed [31:0] set_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      pos_x_o,
  output logic signed [31:0]      pos_y_o,
  output logic signed [31:0]      pos_z_o,
  output logic signed [15:0]      front_x_o,
  output logic signed [15:0]      front_y_o,
  output logic signed [15:0]      front_z_o,
  output logic signed [15:0]      up_x_o,
  output logic signed [15:0]      up_y_o,
  output logic signed [15:0]      up_z_o,
  output logic signed [18:0]      zoom_deg_o
);

  localparam int unsigned CW = fco_pkg::CW;
  localparam int unsigned MW = fco_pkg::MUL_W;
  localparam int unsigned PW = fco_pkg::PROD_W;

  fco_pkg::seq_state_e state_q, state_d;

  logic [15:0]          speed_q;
  logic signed [31:0]   yaw_q, pitch_q;
  logic signed [31:0]   pos_q [3];
  logic signed [15:0]   front_q [3];
  logic signed [15:0]   up_q [3];
  logic signed [15:0]   right_x_q, right_z_q;
  logic signed [18:0]   zoom_q;
  logic [2:0]           dir_q;
  logic [15:0]          dt_hold_q;
  logic [31:0]          vel_q;
  logic [1:0]           k_q, m_q;
  logic signed [CW-1:0] cy_q, sy_q;
  logic                 out_valid_q;

  // cordic and multiplier hookup
  logic                 cor_start, cor_done;
  logic signed [31:0]   cor_angle;
  logic signed [CW-1:0] cor_cos, cor_sin;
  logic                 mul_start, mul_done;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p;

  // accept-time arithmetic
  logic signed [32:0]   yaw_sum, pitch_sum;
  logic signed [31:0]   yaw_new, pitch_new;
  logic signed [20:0]   zoom_sum;
  logic signed [18:0]   zoom_new;
  logic signed [15:0]   mv_comp;
  logic signed [PW:0]   step_full;
  logic signed [CW-1:0] step;
  logic signed [34:0]   pos_sum;
  logic signed [31:0]   pos_new;
  logic                 accept, out_free;

  fco_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .angle_i (cor_angle),
    .done_o  (cor_done),
    .cos_o   (cor_cos),
    .sin_o   (cor_sin)
  );

  fco_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != fco_pkg::S_IDLE);
  assign accept      = in_valid_i && (state_q == fco_pkg::S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  // look: angle update with yaw wrap and pitch clamp
  always_comb begin
    yaw_sum = 33'(yaw_q) + 33'(dx_i) * 33'(fco_pkg::TENTH_Q16);
    pitch_sum = 33'(pitch_q) + 33'(dy_i) * 33'(fco_pkg::TENTH_Q16);
    if (yaw_sum >= 33'(fco_pkg::DEG180)) yaw_sum = yaw_sum - fco_pkg::DEG360;
    else if (yaw_sum < -33'(fco_pkg::DEG180)) yaw_sum = yaw_sum + fco_pkg::DEG360;
    yaw_new = yaw_sum[31:0];
    if (pitch_sum > 33'(fco_pkg::DEG89)) pitch_new = fco_pkg::DEG89;
    else if (pitch_sum < -33'(fco_pkg::DEG89)) pitch_new = -fco_pkg::DEG89;
    else pitch_new = pitch_sum[31:0];
  end

  // zoom update
  always_comb begin
    zoom_sum = 21'(zoom_q) - 21'(dy_i) * 21'sd256;
    if (zoom_q < fco_pkg::ZOOM_MIN) zoom_new = fco_pkg::ZOOM_MIN;
    else if (zoom_q > fco_pkg::ZOOM_MAX) zoom_new = fco_pkg::ZOOM_MAX;
    else if (zoom_sum > 21'sd262143) zoom_new = 19'sd262143;
    else if (zoom_sum < -21'sd262144) zoom_new = -19'sd262144;
    else zoom_new = zoom_sum[18:0];
  end

  // move: pick the vector component for the current axis
  always_comb begin
    case (dir_q)
      fco_pkg::DIR_FWD, fco_pkg::DIR_BACK: mv_comp = front_q[k_q];
      fco_pkg::DIR_RIGHT, fco_pkg::DIR_LEFT: begin
        if (k_q == 2'd0) mv_comp = right_x_q;
        else if (k_q == 2'd2) mv_comp = right_z_q;
        else mv_comp = '0;
      end
      default: mv_comp = up_q[k_q];
    endcase
  end

  // move: rounded step and saturating position update
  always_comb begin
    step_full = ((PW+1)'(mul_p) + ((PW+1)'(1) <<< 21)) >>> 22;
    step = step_full[CW-1:0];
    if (dir_q[0]) pos_sum = 35'(pos_q[k_q]) - 35'(step);
    else pos_sum = 35'(pos_q[k_q]) + 35'(step);
    if (pos_sum > 35'sd2147483647) pos_new = 32'sh7fffffff;
    else if (pos_sum < -35'sd2147483648) pos_new = 32'sh80000000;
    else pos_new = pos_sum[31:0];
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == fco_pkg::S_VEL_GO) begin
      mul_a = MW'(dt_hold_q);
      mul_b = MW'(speed_q);
    end else if (state_q == fco_pkg::S_MV_GO) begin
      mul_a = MW'(mv_comp);
      mul_b = MW'(vel_q);
    end else begin
      case (m_q)
        2'd0: begin mul_a = cy_q;  mul_b = cor_cos; end
        2'd1: begin mul_a = sy_q;  mul_b = cor_cos; end
        2'd2: begin mul_a = -cy_q; mul_b = cor_sin; end
        default: begin mul_a = -sy_q; mul_b = cor_sin; end
      endcase
    end
  end

  assign cor_angle = (state_q == fco_pkg::S_CY_GO) ? yaw_q : pitch_q;

  // sequencer: next state and unit starts
  always_comb begin
    state_d = state_q;
    cor_start = 1'b0;
    mul_start = 1'b0;
    unique case (state_q)
      fco_pkg::S_IDLE: begin
        if (accept) begin
          case (command_i)
            fco_pkg::CMD_LOOK: state_d = fco_pkg::S_CY_GO;
            fco_pkg::CMD_MOVE: begin
              if (move_dir_i == fco_pkg::DIR_FWD || move_dir_i == fco_pkg::DIR_BACK ||
                  move_dir_i == fco_pkg::DIR_RIGHT || move_dir_i == fco_pkg::DIR_LEFT ||
                  move_dir_i == fco_pkg::DIR_UP || move_dir_i == fco_pkg::DIR_DOWN) begin
                state_d = fco_pkg::S_VEL_GO;
              end else begin
                state_d = fco_pkg::S_OUT;
              end
            end
            default: state_d = fco_pkg::S_OUT;
          endcase
        end
      end
      fco_pkg::S_CY_GO: begin
        cor_start = 1'b1;
        state_d = fco_pkg::S_CY_RUN;
      end
      fco_pkg::S_CY_RUN: if (cor_done) state_d = fco_pkg::S_CP_GO;
      fco_pkg::S_CP_GO: begin
        cor_start = 1'b1;
        state_d = fco_pkg::S_CP_RUN;
      end
      fco_pkg::S_CP_RUN: if (cor_done) state_d = fco_pkg::S_LM_GO;
      fco_pkg::S_LM_GO: begin
        mul_start = 1'b1;
        state_d = fco_pkg::S_LM_RUN;
      end
      fco_pkg::S_LM_RUN: begin
        if (mul_done) state_d = (m_q == 2'd3) ? fco_pkg::S_OUT : fco_pkg::S_LM_GO;
      end
      fco_pkg::S_VEL_GO: begin
        mul_start = 1'b1;
        state_d = fco_pkg::S_VEL_RUN;
      end
      fco_pkg::S_VEL_RUN: if (mul_done) state_d = fco_pkg::S_MV_GO;
      fco_pkg::S_MV_GO: begin
        mul_start = 1'b1;
        state_d = fco_pkg::S_MV_RUN;
      end
      fco_pkg::S_MV_RUN: begin
        if (mul_done) state_d = (k_q == 2'd2) ? fco_pkg::S_OUT : fco_pkg::S_MV_GO;
      end
      fco_pkg::S_OUT: if (out_free) state_d = fco_pkg::S_IDLE;
      default: state_d = fco_pkg::S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= fco_pkg::S_IDLE;
    else state_q <= state_d;
  end

  // camera state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q    <= 16'd640;
      yaw_q      <= -fco_pkg::DEG90;
      pitch_q    <= '0;
      pos_q[0]   <= '0;
      pos_q[1]   <= '0;
      pos_q[2]   <= '0;
      front_q[0] <= '0;
      front_q[1] <= '0;
      front_q[2] <= -fco_pkg::ONE_V;
      right_x_q  <= fco_pkg::ONE_V;
      right_z_q  <= '0;
      up_q[0]    <= '0;
      up_q[1]    <= fco_pkg::ONE_V;
      up_q[2]    <= '0;
      zoom_q     <= fco_pkg::ZOOM_MAX;
      k_q        <= '0;
      m_q        <= '0;
    end else begin
      if (cfg_valid_i) speed_q <= move_speed_i;
      if (accept) begin
        k_q <= '0;
        m_q <= '0;
        case (command_i)
          fco_pkg::CMD_LOOK: begin
            yaw_q   <= yaw_new;
            pitch_q <= pitch_new;
          end
          fco_pkg::CMD_ZOOM: zoom_q <= zoom_new;
          fco_pkg::CMD_START: begin
            pos_q[0]   <= set_x_i;
            pos_q[1]   <= set_y_i;
            pos_q[2]   <= set_z_i;
            yaw_q      <= -fco_pkg::DEG90;
            pitch_q    <= '0;
            zoom_q     <= fco_pkg::ZOOM_MAX;
            front_q[0] <= '0;
            front_q[1] <= '0;
            front_q[2] <= -fco_pkg::ONE_V;
            right_x_q  <= fco_pkg::ONE_V;
            right_z_q  <= '0;
            up_q[0]    <= '0;
            up_q[1]    <= fco_pkg::ONE_V;
            up_q[2]    <= '0;
          end
          default: ;
        endcase
      end
      // pitch cordic done: the single-factor components
      if (state_q == fco_pkg::S_CP_RUN && cor_done) begin
        front_q[1] <= fco_pkg::q14_s16(cor_sin);
        up_q[1]    <= fco_pkg::q14_s16(cor_cos);
        right_x_q  <= fco_pkg::q14_s16(-sy_q);
        right_z_q  <= fco_pkg::q14_s16(cy_q);
      end
      // look products: cy cp, sy cp, -cy sp, -sy sp
      if (state_q == fco_pkg::S_LM_RUN && mul_done) begin
        m_q <= m_q + 1'b1;
        case (m_q)
          2'd0: front_q[0] <= fco_pkg::q14_s46(mul_p);
          2'd1: front_q[2] <= fco_pkg::q14_s46(mul_p);
          2'd2: up_q[0]    <= fco_pkg::q14_s46(mul_p);
          default: up_q[2] <= fco_pkg::q14_s46(mul_p);
        endcase
      end
      // move: one axis per product
      if (state_q == fco_pkg::S_MV_RUN && mul_done) begin
        pos_q[k_q] <= pos_new;
        k_q <= k_q + 1'b1;
      end
    end
  end

  // transaction payload held for the sequencer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      dir_q     <= move_dir_i;
      dt_hold_q <= dt_i;
    end
    if (state_q == fco_pkg::S_CY_RUN && cor_done) begin
      cy_q <= cor_cos;
      sy_q <= cor_sin;
    end
    if (state_q == fco_pkg::S_VEL_RUN && mul_done) vel_q <= mul_p[31:0];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == fco_pkg::S_OUT && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == fco_pkg::S_OUT && out_free) begin
      pos_x_o    <= pos_q[0];
      pos_y_o    <= pos_q[1];
      pos_z_o    <= pos_q[2];
      front_x_o  <= front_q[0];
      front_y_o  <= front_q[1];
      front_z_o  <= front_q[2];
      up_x_o     <= up_q[0];
      up_y_o     <= up_q[1];
      up_z_o     <= up_q[2];
      zoom_deg_o <= zoom_q;
    end
  end

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
// testbench for fly_camera_orientation_update: drives look, move, zoom and start
// commands with random gaps and stalls, predicts each result and compares it
// depends on fco_pkg and the fly_camera_orientation_update rtl
`timescale 1ns / 1ps

module testbench;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] speed_w = 16'd0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] cmd = fco_pkg::CMD_LOOK;
  logic signed [10:0] dx = '0, dy = '0;
  logic [2:0] mdir = fco_pkg::DIR_FWD;
  logic [15:0] dt = '0;
  logic signed [31:0] sx = '0, sy = '0, sz = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] px, py, pz;
  logic signed [15:0] fx, fy, fz, ux, uy, uz;
  logic signed [18:0] zm;

  int errors = 0;
  int cycles = 0;
  bit drive_done = 1'b0;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int TAIL_CYCLES = 400;

  typedef struct packed {
    logic signed [31:0] p_x, p_y, p_z;
    logic signed [15:0] f_x, f_y, f_z, u_x, u_y, u_z;
    logic signed [18:0] z;
  } cam_view_t;

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout waiting for camera results");
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  // predicts the camera state after each command and checks results in order
  class camera_scoreboard;
    longint yaw, pitch, spd;
    longint pos[3], fv[3], rv[3], uv[3];
    longint zoom;
    cam_view_t pending[$];

    function longint rnd_sh(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint lim(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint unit(longint v, int s);
      return lim(rnd_sh(v, s), -16384, 16384);
    endfunction

    function longint atan_at(int i);
      longint tbl[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                          29335, 14667, 7334, 3667, 1833, 917, 458, 229, 115, 57,
                          29, 14, 7, 4, 2, 1, 0};
      return tbl[i];
    endfunction

    function void sin_cos(longint a, output longint c, output longint s);
      bit flip;
      longint x, y, xs, ys;
      flip = 0;
      x = 652032874;
      y = 0;
      if (a > 90 * 65536) begin
        a -= 180 * 65536;
        flip = 1;
      end else if (a < -90 * 65536) begin
        a += 180 * 65536;
        flip = 1;
      end
      for (int i = 0; i < 16; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (a >= 0) begin
          x -= ys; y += xs; a -= atan_at(i);
        end else begin
          x += ys; y -= xs; a += atan_at(i);
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function void basis_home();
      fv = '{0, 0, -16384};
      rv = '{16384, 0, 0};
      uv = '{0, 16384, 0};
    endfunction

    function void home();
      yaw = -90 * 65536;
      pitch = 0;
      pos = '{0, 0, 0};
      basis_home();
      zoom = 11520;
      spd = 640;
    endfunction

    function void set_speed(logic [15:0] v);
      spd = longint'(v);
    endfunction

    function void note_command(logic [1:0] c, logic signed [10:0] ddx,
                               logic signed [10:0] ddy, logic [2:0] d,
                               logic [15:0] t, logic signed [31:0] ax,
                               logic signed [31:0] ay, logic signed [31:0] az);
      longint ny, np, cy, syv, cp, sp, vel, st;
      longint vec[3];
      int sgn;
      cam_view_t e;
      case (c)
        fco_pkg::CMD_LOOK: begin
          ny = yaw + longint'(ddx) * 6554;
          np = pitch + longint'(ddy) * 6554;
          if (ny >= 180 * 65536) ny -= 360 * 65536;
          else if (ny < -180 * 65536) ny += 360 * 65536;
          yaw = ny;
          pitch = lim(np, -89 * 65536, 89 * 65536);
          sin_cos(yaw, cy, syv);
          sin_cos(pitch, cp, sp);
          fv = '{unit(cy * cp, 46), unit(sp, 16), unit(syv * cp, 46)};
          rv = '{unit(-syv, 16), 0, unit(cy, 16)};
          uv = '{unit(-cy * sp, 46), unit(cp, 16), unit(-syv * sp, 46)};
        end
        fco_pkg::CMD_MOVE: begin
          vel = longint'(t) * spd;
          sgn = d[0] ? -1 : 1;
          if (d <= fco_pkg::DIR_BACK) vec = fv;
          else if (d <= fco_pkg::DIR_LEFT) vec = rv;
          else vec = uv;
          if (d <= fco_pkg::DIR_DOWN)
            for (int k = 0; k < 3; k++) begin
              st = rnd_sh(vec[k] * vel, 22);
              pos[k] = lim(pos[k] + sgn * st, -64'sd2147483648, 64'sd2147483647);
            end
        end
        fco_pkg::CMD_ZOOM: begin
          if (zoom >= 256 && zoom <= 11520) zoom = lim(zoom - longint'(ddy) * 256,
                                                      -262144, 262143);
          else if (zoom < 256) zoom = 256;
          else zoom = 11520;
        end
        default: begin
          pos = '{longint'(ax), longint'(ay), longint'(az)};
          yaw = -90 * 65536;
          pitch = 0;
          zoom = 11520;
          basis_home();
        end
      endcase
      e.p_x = 32'(pos[0]); e.p_y = 32'(pos[1]); e.p_z = 32'(pos[2]);
      e.f_x = 16'(fv[0]); e.f_y = 16'(fv[1]); e.f_z = 16'(fv[2]);
      e.u_x = 16'(uv[0]); e.u_y = 16'(uv[1]); e.u_z = 16'(uv[2]);
      e.z = 19'(zoom);
      pending.push_back(e);
    endfunction

    task check_view(cam_view_t got);
      cam_view_t e;
      if (pending.size() == 0) begin
        report("result with no command outstanding");
        return;
      end
      e = pending.pop_front();
      if (got.p_x !== e.p_x) report($sformatf("pos_x %0d exp %0d", got.p_x, e.p_x));
      if (got.p_y !== e.p_y) report($sformatf("pos_y %0d exp %0d", got.p_y, e.p_y));
      if (got.p_z !== e.p_z) report($sformatf("pos_z %0d exp %0d", got.p_z, e.p_z));
      if (got.f_x !== e.f_x) report($sformatf("front_x %0d exp %0d", got.f_x, e.f_x));
      if (got.f_y !== e.f_y) report($sformatf("front_y %0d exp %0d", got.f_y, e.f_y));
      if (got.f_z !== e.f_z) report($sformatf("front_z %0d exp %0d", got.f_z, e.f_z));
      if (got.u_x !== e.u_x) report($sformatf("up_x %0d exp %0d", got.u_x, e.u_x));
      if (got.u_y !== e.u_y) report($sformatf("up_y %0d exp %0d", got.u_y, e.u_y));
      if (got.u_z !== e.u_z) report($sformatf("up_z %0d exp %0d", got.u_z, e.u_z));
      if (got.z !== e.z) report($sformatf("zoom %0d exp %0d", got.z, e.z));
    endtask
  endclass

  camera_scoreboard cam_sb = new();

  fly_camera_orientation_update i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .move_speed_i(speed_w),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .command_i(cmd), .dx_i(dx), .dy_i(dy), .move_dir_i(mdir), .dt_i(dt),
    .set_x_i(sx), .set_y_i(sy), .set_z_i(sz),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .pos_x_o(px), .pos_y_o(py), .pos_z_o(pz),
    .front_x_o(fx), .front_y_o(fy), .front_z_o(fz),
    .up_x_o(ux), .up_y_o(uy), .up_z_o(uz), .zoom_deg_o(zm)
  );

  // result side: random stalls, check each accepted transaction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      cam_sb.check_view('{px, py, pz, fx, fy, fz, ux, uy, uz, zm});
    if (rst_n) out_stall <= ($urandom_range(0, 99) < 30) && !drive_done;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // valid stays high across back-to-back transactions, drops only for a gap, a speed write or the end of the run
  task automatic send_cmd(input logic [1:0] c, input logic signed [10:0] a,
                          input logic signed [10:0] b, input logic [2:0] d,
                          input logic [15:0] t, input logic signed [31:0] x,
                          input logic signed [31:0] y, input logic signed [31:0] z);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    cmd <= c; dx <= a; dy <= b; mdir <= d; dt <= t;
    sx <= x; sy <= y; sz <= z;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    cam_sb.note_command(c, a, b, d, t, x, y, z);
  endtask

  task automatic write_speed(input logic [15:0] v);
    in_valid <= 1'b0;
    while (cam_sb.pending.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    speed_w <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cam_sb.set_speed(v);
  endtask

  task automatic random_cmd();
    logic [1:0] c;
    c = 2'($urandom_range(0, 3));
    if (c == fco_pkg::CMD_START && $urandom_range(0, 3) != 0) c = fco_pkg::CMD_MOVE;
    send_cmd(c, 11'($urandom), 11'($urandom),
             ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                         : 3'($urandom_range(0, 5)),
             ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000)),
             ($urandom_range(0, 3) == 0) ? 32'($urandom)
                 : 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21)),
             $urandom, ($urandom_range(0, 1) == 0) ? 32'h7fff_ff00 : 32'($urandom));
  endtask

  initial begin
    cam_sb.home();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every command, field extremes, clamps and wraps
    send_cmd(fco_pkg::CMD_MOVE, 0, 0, fco_pkg::DIR_FWD, 16'hffff, 0, 0, 0);
    send_cmd(fco_pkg::CMD_LOOK, 11'sd1023, 11'sd1023, fco_pkg::DIR_FWD, 0, 0, 0, 0);
    send_cmd(fco_pkg::CMD_LOOK, -11'sd1024, -11'sd1024, fco_pkg::DIR_FWD, 0, 0, 0, 0);
    send_cmd(fco_pkg::CMD_LOOK, 11'sd1023, 11'sd500, fco_pkg::DIR_FWD, 0, 0, 0, 0);
    send_cmd(fco_pkg::CMD_LOOK, 11'sd1023, 11'sd0, fco_pkg::DIR_FWD, 0, 0, 0, 0);
    for (int d = 0; d < 8; d++)
      send_cmd(fco_pkg::CMD_MOVE, 0, 0, 3'(d), 16'hffff, 0, 0, 0);
    send_cmd(fco_pkg::CMD_START, 0, 0, fco_pkg::DIR_FWD, 0, 32'sh7fffffff, 32'sh80000000,
             -1);
    send_cmd(fco_pkg::CMD_MOVE, 0, 0, fco_pkg::DIR_BACK, 16'hffff, 0, 0, 0);
    send_cmd(fco_pkg::CMD_LOOK, 11'sd0, 11'sd0, fco_pkg::DIR_FWD, 0, 0, 0, 0);
    send_cmd(fco_pkg::CMD_ZOOM, 0, 11'sd1023, fco_pkg::DIR_FWD, 0, 0, 0, 0);
    send_cmd(fco_pkg::CMD_ZOOM, 0, 11'sd5, fco_pkg::DIR_FWD, 0, 0, 0, 0);
    send_cmd(fco_pkg::CMD_ZOOM, 0, -11'sd1024, fco_pkg::DIR_FWD, 0, 0, 0, 0);
    send_cmd(fco_pkg::CMD_ZOOM, 0, 11'sd0, fco_pkg::DIR_FWD, 0, 0, 0, 0);
    send_cmd(fco_pkg::CMD_ZOOM, 0, 11'sd44, fco_pkg::DIR_FWD, 0, 0, 0, 0);
    send_cmd(fco_pkg::CMD_START, 0, 0, fco_pkg::DIR_FWD, 0, 0, 0, 0);

    // random phases through several speed settings
    write_speed(16'hffff);
    for (int i = 0; i < 250; i++) random_cmd();
    write_speed(16'h0000);
    for (int i = 0; i < 150; i++) random_cmd();
    write_speed(16'($urandom));
    for (int i = 0; i < 250; i++) random_cmd();
    write_speed(16'd640);
    for (int i = 0; i < 250; i++) random_cmd();

    in_valid <= 1'b0;
    drive_done = 1'b1;
    while (cam_sb.pending.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
